>>> sv/dbu_pkg.sv
// shared types and constants of the debug breakpoint unit
`timescale 1ns / 1ps

package dbu_pkg;

  localparam int MODE_W      = 3;
  localparam int KIND_W      = 4;
  localparam int WORD_W      = 32;
  localparam int MASK_W      = 16;
  localparam int FIRST_W     = 4;
  localparam int COUNT_OUT_W = 5;

  // address window span and fetch step used by the mem and fwbranch matches
  localparam logic [WORD_W-1:0] WINDOW_SPAN = 32'd7;
  localparam logic [WORD_W-1:0] FETCH_STEP  = 32'd4;

  // breakpoint entry types
  localparam logic [KIND_W-1:0] TYPE_PC         = 4'd0;
  localparam logic [KIND_W-1:0] TYPE_MEM        = 4'd1;
  localparam logic [KIND_W-1:0] TYPE_MEMR       = 4'd2;
  localparam logic [KIND_W-1:0] TYPE_MEMW       = 4'd3;
  localparam logic [KIND_W-1:0] TYPE_NEXTCALL   = 4'd4;
  localparam logic [KIND_W-1:0] TYPE_NEXTRET    = 4'd5;
  localparam logic [KIND_W-1:0] TYPE_FWBRANCH   = 4'd6;
  localparam logic [KIND_W-1:0] TYPE_NEXTTHREAD = 4'd7;
  localparam logic [KIND_W-1:0] TYPE_NEXTFRAME  = 4'd8;
  localparam logic [KIND_W-1:0] TYPE_MSG        = 4'd9;

  // branch kinds
  localparam logic [KIND_W-1:0] BR_NORMAL = 4'd0;
  localparam logic [KIND_W-1:0] BR_CALL   = 4'd1;
  localparam logic [KIND_W-1:0] BR_RET    = 4'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 3'd0,
    MODE_ADD    = 3'd1,
    MODE_ARM    = 3'd2,
    MODE_FETCH  = 3'd3,
    MODE_ACCESS = 3'd4,
    MODE_BRANCH = 3'd5,
    MODE_MSG    = 3'd6,
    MODE_CHECK  = 3'd7
  } dbu_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } dbu_state_e;

  typedef struct packed {
    dbu_mode_e          mode;
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  address;
    logic [WORD_W-1:0]  value;
    logic               is_write;
    logic [WORD_W-1:0]  current_pc;
    logic [WORD_W-1:0]  thread_id;
    logic [WORD_W-1:0]  frame_count;
  } dbu_in_t;

  typedef struct packed {
    logic [MASK_W-1:0]      hit_mask;
    logic                   hit_any;
    logic [FIRST_W-1:0]     first_hit;
    logic                   table_full;
    logic [COUNT_OUT_W-1:0] entry_count;
  } dbu_out_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic eval_en;
    logic finish;
  } dbu_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic last_entry;
  } dbu_status_t;

endpackage

>>> sv/dbu_ctrl.sv
// sequencer of the debug breakpoint unit
`timescale 1ns / 1ps

module dbu_ctrl import dbu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  dbu_status_t status_i,
  output dbu_cmd_t    cmd_o,
  output logic        busy_o
);

  dbu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = status_i.scan_needed ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: state_d = status_i.last_entry ? ST_DONE : ST_READ;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_READ: cmd_o.rd_en   = 1'b1;
      ST_EVAL: cmd_o.eval_en = 1'b1;
      ST_DONE: cmd_o.finish  = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  // an accepted transaction always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("controller stayed idle after start");

  // every evaluation step follows a read of the entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eval_en |-> $past(cmd_o.rd_en))
    else $error("evaluation without entry read");

  // the done step always hands back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy_o)
    else $error("controller busy after done step");

endmodule

>>> sv/dbu_datapath.sv
// entry memories, match logic and result register of the debug breakpoint unit
`timescale 1ns / 1ps

module dbu_datapath import dbu_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dbu_in_t     item_i,
  input  dbu_cmd_t    cmd_i,
  output dbu_status_t status_o,
  output logic        result_valid_o,
  output dbu_out_t    result_o
);

  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic [KIND_W-1:0] type_mem [NUM_ENTRIES];
  logic [WORD_W-1:0] addr_mem [NUM_ENTRIES];
  logic [WORD_W-1:0] data_mem [NUM_ENTRIES];

  dbu_in_t           item_q;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     idx_q;
  logic [MASK_W-1:0] mask_q;
  logic              found_q;
  logic [FIRST_W-1:0] first_q;
  logic [KIND_W-1:0] rd_type_q;
  logic [WORD_W-1:0] rd_addr_q, rd_data_q;
  logic              valid_q;
  dbu_out_t          result_q;

  logic              add_ok, add_full;
  logic              hit, data_we;
  logic [WORD_W-1:0] data_new, win_end, pc_step;
  logic              mem_we, dmem_we;
  logic [IW-1:0]     mem_waddr;
  logic [WORD_W-1:0] dmem_wdata;

  // status for the sequencer; scan decision is taken on the incoming item
  assign status_o.scan_needed = (item_i.mode != MODE_CLEAR) && (item_i.mode != MODE_ADD)
                                && (count_q != '0);
  assign status_o.last_entry  = (CW'(idx_q) + CW'(1)) == count_q;

  assign add_ok   = (item_q.mode == MODE_ADD) && (count_q < CW'(NUM_ENTRIES));
  assign add_full = (item_q.mode == MODE_ADD) && !add_ok;

  // per-entry match and data update
  always_comb begin
    hit      = 1'b0;
    data_we  = 1'b0;
    data_new = rd_data_q;
    win_end  = rd_addr_q + WINDOW_SPAN;
    pc_step  = item_q.current_pc + FETCH_STEP;
    unique case (item_q.mode)
      MODE_CLEAR, MODE_ADD: begin
        hit = 1'b0;
      end
      MODE_ARM: begin
        case (rd_type_q)
          TYPE_NEXTTHREAD: begin
            data_new = item_q.thread_id;
            data_we  = 1'b1;
          end
          TYPE_NEXTFRAME: begin
            data_new = item_q.frame_count;
            data_we  = 1'b1;
          end
          TYPE_NEXTRET: begin
            data_new = '0;
            data_we  = 1'b1;
          end
          default: data_we = 1'b0;
        endcase
      end
      MODE_FETCH: hit = (rd_type_q == TYPE_PC) && (item_q.address == rd_addr_q);
      MODE_ACCESS: begin
        case (rd_type_q)
          TYPE_MEM:  hit = (item_q.address >= rd_addr_q) && (item_q.address <= win_end);
          TYPE_MEMR: hit = !item_q.is_write && (item_q.address == rd_addr_q);
          TYPE_MEMW: hit = item_q.is_write && (item_q.address == rd_addr_q);
          default:   hit = 1'b0;
        endcase
      end
      MODE_BRANCH: begin
        case (rd_type_q)
          TYPE_NEXTCALL: hit = (item_q.kind == BR_CALL);
          TYPE_NEXTRET: begin
            // call depth counter, fires once it goes negative
            if (item_q.kind == BR_CALL) begin
              data_new = rd_data_q + WORD_W'(1);
              data_we  = 1'b1;
            end else if (item_q.kind == BR_RET) begin
              data_new = rd_data_q - WORD_W'(1);
              data_we  = 1'b1;
              hit      = data_new[WORD_W-1];
            end
          end
          TYPE_FWBRANCH: hit = (item_q.kind == BR_NORMAL) && (item_q.address > pc_step);
          default:       hit = 1'b0;
        endcase
      end
      MODE_MSG: hit = (rd_type_q == TYPE_MSG) && (item_q.value == rd_data_q);
      MODE_CHECK: begin
        case (rd_type_q)
          TYPE_NEXTTHREAD: hit = item_q.thread_id != rd_data_q;
          TYPE_NEXTFRAME:  hit = item_q.frame_count != rd_data_q;
          default:         hit = 1'b0;
        endcase
      end
      default: hit = 1'b0;
    endcase
  end

  // single write port per memory: add at the fill point, or data write-back
  assign mem_we     = cmd_i.finish && add_ok;
  assign dmem_we    = mem_we || (cmd_i.eval_en && data_we);
  assign mem_waddr  = cmd_i.finish ? count_q[IW-1:0] : idx_q;
  assign dmem_wdata = cmd_i.finish ? item_q.value : data_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      type_mem[mem_waddr] <= item_q.kind;
      addr_mem[mem_waddr] <= item_q.address;
    end
    if (dmem_we) begin
      data_mem[mem_waddr] <= dmem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_type_q <= type_mem[idx_q];
      rd_addr_q <= addr_mem[idx_q];
      rd_data_q <= data_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.finish) begin
      if (item_q.mode == MODE_CLEAR) begin
        count_d = '0;
      end else if (add_ok) begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      mask_q  <= '0;
      found_q <= 1'b0;
      first_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= cmd_i.finish;
      if (cmd_i.load) begin
        idx_q   <= '0;
        mask_q  <= '0;
        found_q <= 1'b0;
        first_q <= '0;
      end else if (cmd_i.eval_en) begin
        idx_q <= idx_q + IW'(1);
        if (hit) begin
          // entries past the mask width still count for hit_any and first_hit
          mask_q <= mask_q | (MASK_W'(1) << idx_q);
          if (!found_q) begin
            found_q <= 1'b1;
            first_q <= FIRST_W'(idx_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_q.hit_mask    <= mask_q;
      result_q.hit_any     <= found_q;
      result_q.first_hit   <= first_q;
      result_q.table_full  <= add_full;
      result_q.entry_count <= COUNT_OUT_W'(count_d);
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NUM_ENTRIES))
    else $error("entry count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && result_q.table_full |-> count_q == CW'(NUM_ENTRIES))
    else $error("add refused while table not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (result_q.hit_mask != '0) |-> result_q.hit_any)
    else $error("hit mask set without hit_any");

endmodule

>>> sv/debug_breakpoint_unit.sv
// top level of the debug breakpoint and watchpoint unit
//
//   channel   signals                      handshake
//   --------  ---------------------------  ----------------------------------
//   command   start_i, item_i, busy_o      taken at edge with start_i & !busy_o
//   result    result_valid_o, result_o     one-cycle strobe, always taken
//
// a table op (clear, add) or any item on an empty table goes from acceptance
// straight to the done step; arm and event items first read then evaluate
// each of the n entries in use in turn, one entry at a time, before the done step,
// through the single-port entry memories
// the result strobe comes in the cycle after the last busy cycle
// reset clears the entry count and the sequencer; entry contents stay undefined
// the receiver cannot stall, so busy_o depends only on the work in progress
`timescale 1ns / 1ps

module debug_breakpoint_unit import dbu_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dbu_in_t  item_i,
  output logic     busy_o,
  output logic     result_valid_o,
  output dbu_out_t result_o
);

  // command and status between sequencer and datapath
  dbu_cmd_t    cmd;
  dbu_status_t status;

  // sequencer: idle -> (read -> eval)* -> done
  dbu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // entry storage, per-entry match, hit collection and result register
  dbu_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
